// ===== rtl/core/vsc_pkg.sv =====
// shared types, constants and helpers for the voxel skeleton classifier
package vsc_pkg;

	localparam int OFFSET_BITS = 8;
	localparam int PACK_BITS   = 24;
	localparam int NUM_NBR     = 6;
	localparam int CNT_BITS    = 3;
	localparam int CFG_IDX_BITS = 1;
	localparam int CFG_DATA_BITS = 16;
	localparam int THR_BITS    = 16;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_COS_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_NEIGHBOR_MODE = 1'd1;

	localparam logic signed [THR_BITS-1:0] COS_RESET = 16'sd22938;

	// r component: neighbor offset plus one step
	localparam int R_BITS   = OFFSET_BITS + 1;
	// one product of r and p components
	localparam int PR_BITS  = R_BITS + OFFSET_BITS;
	// dot product over three axes
	localparam int DOT_BITS = PR_BITS + 2;
	// squared magnitudes
	localparam int RM_BITS  = 2 * R_BITS + 1;
	localparam int PM_BITS  = 2 * OFFSET_BITS + 1;
	// |dot| scaled by 2^15, then squared
	localparam int AD_BITS  = DOT_BITS;
	localparam int L_BITS   = 2 * AD_BITS + 30;
	// t^2 * |r|^2 * |p|^2
	localparam int MM_BITS  = RM_BITS + PM_BITS;
	localparam int T2_BITS  = 2 * THR_BITS;
	localparam int RHS_BITS = T2_BITS + MM_BITS;
	localparam int CMP_BITS = (L_BITS > RHS_BITS) ? L_BITS : RHS_BITS;

	typedef logic signed [OFFSET_BITS-1:0] off_t;
	typedef logic signed [R_BITS-1:0] rcomp_t;

	typedef struct packed {
		logic                        valid;
		logic                        mode;
		logic                        thr_neg;
		logic [NUM_NBR-1:0]          use_nbr;
	} vsc_ctl_t;

	function automatic off_t axis_of(input logic [PACK_BITS-1:0] packed_v, input int axis);
		axis_of = off_t'(packed_v[axis*OFFSET_BITS +: OFFSET_BITS]);
	endfunction

endpackage

// ===== rtl/core/voxel_skeleton_classifier.sv =====
// top level of the voxel skeleton classifier
// result strobe: start passes through ctl_s1, ctl_s2 and ctl_s3 into the registered done
// throughput: one word per cycle, six neighbor lanes in a four-stage pipeline
// stages: products, squared terms, compare, count and class
// reset: arst_n clears valid bits and restores cos_threshold 22938, mode 0
// the receiver cannot stall; busy is tied low
module voxel_skeleton_classifier (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  cfg_we,
	input  logic [vsc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [vsc_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	input  logic [vsc_pkg::PACK_BITS-1:0]         center_parent,
	input  logic                                  center_ok,
	input  logic [vsc_pkg::PACK_BITS-1:0]         nbr_xm_parent,
	input  logic [vsc_pkg::PACK_BITS-1:0]         nbr_xp_parent,
	input  logic [vsc_pkg::PACK_BITS-1:0]         nbr_ym_parent,
	input  logic [vsc_pkg::PACK_BITS-1:0]         nbr_yp_parent,
	input  logic [vsc_pkg::PACK_BITS-1:0]         nbr_zm_parent,
	input  logic [vsc_pkg::PACK_BITS-1:0]         nbr_zp_parent,
	input  logic [vsc_pkg::NUM_NBR-1:0]           nbr_ok_mask,
	output logic                                  done,
	output logic                                  on_skel,
	output logic [vsc_pkg::CNT_BITS-1:0]          basis_count,
	output logic                                  is_face,
	output logic                                  is_edge,
	output logic                                  is_vtx
);

	logic signed [vsc_pkg::THR_BITS-1:0] cos_q;
	logic mode_q;
	logic [vsc_pkg::THR_BITS-1:0] abs_thr;
	logic [vsc_pkg::T2_BITS-1:0] thr_sq;
	logic [vsc_pkg::PACK_BITS-1:0] nbr [vsc_pkg::NUM_NBR];
	logic [vsc_pkg::NUM_NBR-1:0] pass_s3;
	logic ctr_live;
	vsc_pkg::vsc_ctl_t ctl_in, ctl_s1, ctl_s2, ctl_s3;
	logic [vsc_pkg::CNT_BITS-1:0] cnt;

	// no word holds up the next one, so the block never blocks start
	assign busy = 1'b0;

	// config registers; the user writes them only while idle, the block itself does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q  <= vsc_pkg::COS_RESET;
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vsc_pkg::REG_COS_THRESHOLD: cos_q  <= cfg_data;
				vsc_pkg::REG_NEIGHBOR_MODE: mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// t^2 is static between config writes
	assign abs_thr = cos_q[vsc_pkg::THR_BITS-1] ? vsc_pkg::THR_BITS'(-cos_q)
		: vsc_pkg::THR_BITS'(cos_q);
	assign thr_sq  = vsc_pkg::T2_BITS'(abs_thr) * vsc_pkg::T2_BITS'(abs_thr);

	assign nbr[0] = nbr_xm_parent;
	assign nbr[1] = nbr_xp_parent;
	assign nbr[2] = nbr_ym_parent;
	assign nbr[3] = nbr_yp_parent;
	assign nbr[4] = nbr_zm_parent;
	assign nbr[5] = nbr_zp_parent;

	// zero center parent or unusable center gives no skeleton
	assign ctr_live = center_ok && (center_parent[3*vsc_pkg::OFFSET_BITS-1:0] != '0);

	assign ctl_in.valid   = start;
	assign ctl_in.mode    = mode_q;
	assign ctl_in.thr_neg = cos_q[vsc_pkg::THR_BITS-1];
	assign ctl_in.use_nbr = ctr_live ? nbr_ok_mask : '0;

	// six lanes, one per face neighbor; lane k steps on axis k/2
	for (genvar k = 0; k < vsc_pkg::NUM_NBR; k++) begin : g_lane
		vsc_sep_lane u_lane (
			.clk        (clk),
			.step_axis  (3'(1 << (k / 2))),
			.step_pos   (1'((k % 2))),
			.nbr_parent (nbr[k]),
			.ctr_parent (center_parent),
			.thr_sq     (thr_sq),
			.thr_neg    (ctl_in.thr_neg),
			.pass_s3    (pass_s3[k])
		);
	end

	// control travels alongside the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	// count of passing, usable lanes
	always_comb begin
		cnt = '0;
		for (int k = 0; k < vsc_pkg::NUM_NBR; k++)
			cnt = cnt + vsc_pkg::CNT_BITS'(pass_s3[k] & ctl_s3.use_nbr[k]);
	end

	// stage 4: class and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= ctl_s3.valid;
	end

	always_ff @(posedge clk) begin
		basis_count <= cnt;
		on_skel     <= (cnt != '0);
		if (ctl_s3.mode) begin
			is_face <= (cnt != '0);
			is_edge <= 1'b0;
			is_vtx  <= 1'b0;
		end else begin
			is_face <= (cnt == 3'd2);
			is_edge <= (cnt == 3'd3);
			is_vtx  <= (cnt == 3'd4);
		end
	end

	// a word leaves through ctl_s1, ctl_s2, ctl_s3 and the done register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##4 done) else $error("result word lost");
	a_class_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $onehot0({is_face, is_edge, is_vtx})) else $error("class not exclusive");
	a_skel: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (on_skel == (basis_count != '0))) else $error("skeleton flag mismatch");

endmodule

// ===== rtl/core/vsc_sep_lane.sv =====
// one neighbor lane: forms r, dot and magnitudes, and the exact cosine test
module vsc_sep_lane (
	input  logic                                    clk,
	input  logic [2:0]                              step_axis,
	input  logic                                    step_pos,
	input  logic [vsc_pkg::PACK_BITS-1:0]           nbr_parent,
	input  logic [vsc_pkg::PACK_BITS-1:0]           ctr_parent,
	input  logic [vsc_pkg::T2_BITS-1:0]             thr_sq,
	input  logic                                    thr_neg,
	output logic                                    pass_s3
);

	vsc_pkg::rcomp_t r [3];
	logic signed [vsc_pkg::PR_BITS-1:0] prod_s1 [3];
	logic [vsc_pkg::RM_BITS-1:0] rmag_s1;
	logic [vsc_pkg::PM_BITS-1:0] pmag_s1;
	logic rzero_s1;
	logic signed [vsc_pkg::DOT_BITS-1:0] dot;
	logic [vsc_pkg::AD_BITS-1:0] adot;
	logic [vsc_pkg::L_BITS-1:0] lhs_s2;
	logic [vsc_pkg::MM_BITS-1:0] mm_s2;
	logic dpos_s2, dneg_s2, rzero_s2;
	logic [vsc_pkg::RHS_BITS-1:0] rhs;
	logic [vsc_pkg::CMP_BITS-1:0] lhs_x, rhs_x;
	logic [vsc_pkg::T2_BITS-1:0] thr_sq_s2;
	logic thr_neg_s2;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			r[a] = vsc_pkg::rcomp_t'(vsc_pkg::axis_of(nbr_parent, a));
			if (step_axis[a])
				r[a] = step_pos ? r[a] + vsc_pkg::rcomp_t'(1) : r[a] - vsc_pkg::rcomp_t'(1);
		end
	end

	// stage 1: per-axis products and magnitudes
	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++)
			prod_s1[a] <= vsc_pkg::PR_BITS'(r[a])
				* vsc_pkg::PR_BITS'(vsc_pkg::axis_of(ctr_parent, a));
		rmag_s1 <= vsc_pkg::RM_BITS'(r[0]) * vsc_pkg::RM_BITS'(r[0])
			+ vsc_pkg::RM_BITS'(r[1]) * vsc_pkg::RM_BITS'(r[1])
			+ vsc_pkg::RM_BITS'(r[2]) * vsc_pkg::RM_BITS'(r[2]);
		pmag_s1 <= vsc_pkg::PM_BITS'(vsc_pkg::axis_of(ctr_parent, 0))
				* vsc_pkg::PM_BITS'(vsc_pkg::axis_of(ctr_parent, 0))
			+ vsc_pkg::PM_BITS'(vsc_pkg::axis_of(ctr_parent, 1))
				* vsc_pkg::PM_BITS'(vsc_pkg::axis_of(ctr_parent, 1))
			+ vsc_pkg::PM_BITS'(vsc_pkg::axis_of(ctr_parent, 2))
				* vsc_pkg::PM_BITS'(vsc_pkg::axis_of(ctr_parent, 2));
		rzero_s1 <= (r[0] == '0) && (r[1] == '0) && (r[2] == '0);
	end

	assign dot = vsc_pkg::DOT_BITS'(prod_s1[0]) + vsc_pkg::DOT_BITS'(prod_s1[1])
		+ vsc_pkg::DOT_BITS'(prod_s1[2]);
	assign adot = dot[vsc_pkg::DOT_BITS-1] ? vsc_pkg::AD_BITS'(-dot) : vsc_pkg::AD_BITS'(dot);

	// stage 2: squared scaled dot and magnitude product
	always_ff @(posedge clk) begin
		lhs_s2     <= {(2 * vsc_pkg::AD_BITS)'(adot) * (2 * vsc_pkg::AD_BITS)'(adot), 30'd0};
		mm_s2      <= vsc_pkg::MM_BITS'(rmag_s1) * vsc_pkg::MM_BITS'(pmag_s1);
		dpos_s2    <= !dot[vsc_pkg::DOT_BITS-1] && (dot != '0);
		dneg_s2    <= dot[vsc_pkg::DOT_BITS-1];
		rzero_s2   <= rzero_s1;
		thr_sq_s2  <= thr_sq;
		thr_neg_s2 <= thr_neg;
	end

	assign rhs   = vsc_pkg::RHS_BITS'(thr_sq_s2) * vsc_pkg::RHS_BITS'(mm_s2);
	assign lhs_x = vsc_pkg::CMP_BITS'(lhs_s2);
	assign rhs_x = vsc_pkg::CMP_BITS'(rhs);

	// stage 3: sign-aware compare
	always_ff @(posedge clk) begin
		if (rzero_s2)
			pass_s3 <= 1'b0;
		else if (!thr_neg_s2)
			pass_s3 <= !dpos_s2 || (lhs_x <= rhs_x);
		else
			pass_s3 <= dneg_s2 && (rhs_x <= lhs_x);
	end

endmodule

// ===== verif/tb.sv =====
// self-checking testbench for the voxel skeleton classifier
`timescale 1ns / 100ps

module tb;

	typedef struct {
		logic [vsc_pkg::PACK_BITS-1:0] center;
		logic                          ok;
		logic [vsc_pkg::PACK_BITS-1:0] nbr [vsc_pkg::NUM_NBR];
		logic [vsc_pkg::NUM_NBR-1:0]   mask;
	} voxel_t;

	typedef struct {
		logic                         on;
		logic [vsc_pkg::CNT_BITS-1:0] cnt;
		logic                         face;
		logic                         edge_c;
		logic                         vert;
	} class_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic cfg_we = 1'b0;
	logic [vsc_pkg::CFG_IDX_BITS-1:0] cfg_index = vsc_pkg::REG_COS_THRESHOLD;
	logic [vsc_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
	logic [vsc_pkg::PACK_BITS-1:0] center_parent = '0;
	logic center_ok = 1'b0;
	logic [vsc_pkg::PACK_BITS-1:0] nbr_xm_parent = '0, nbr_xp_parent = '0, nbr_ym_parent = '0;
	logic [vsc_pkg::PACK_BITS-1:0] nbr_yp_parent = '0, nbr_zm_parent = '0, nbr_zp_parent = '0;
	logic [vsc_pkg::NUM_NBR-1:0] nbr_ok_mask = '0;
	logic done, on_skel, is_face, is_edge, is_vtx;
	logic [vsc_pkg::CNT_BITS-1:0] basis_count;

	// shadow of the configuration registers
	logic signed [vsc_pkg::THR_BITS-1:0] cur_thr = vsc_pkg::COS_RESET;
	logic cur_mode = 1'b0;

	class_t expected_classes [$];
	int errors = 0;
	int words_sent = 0;
	int results_seen = 0;
	int idle_cycles = 0;
	logic quiet = 1'b1;  // no random gaps when set

	voxel_skeleton_classifier uut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// signed offset on one axis of a packed parent
	function automatic longint offset_of(logic [vsc_pkg::PACK_BITS-1:0] v, int a);
		logic signed [vsc_pkg::OFFSET_BITS-1:0] s;
		s = v[a*vsc_pkg::OFFSET_BITS +: vsc_pkg::OFFSET_BITS];
		return longint'(s);
	endfunction

	// exact cosine test without normalization
	function automatic bit is_separated(longint r [3], longint p [3],
			logic signed [vsc_pkg::THR_BITS-1:0] t);
		longint dot, absd, at, mr, mp;
		logic [127:0] lhs, rhs;
		dot = r[0]*p[0] + r[1]*p[1] + r[2]*p[2];
		absd = dot < 0 ? -dot : dot;
		at = t < 0 ? -longint'(t) : longint'(t);
		mr = r[0]*r[0] + r[1]*r[1] + r[2]*r[2];
		mp = p[0]*p[0] + p[1]*p[1] + p[2]*p[2];
		lhs = 128'(absd) * 128'd32768;
		lhs = lhs * lhs;
		rhs = 128'(at*at) * 128'(mr) * 128'(mp);
		if (t >= 0)
			return dot <= 0 || lhs <= rhs;
		return dot < 0 && rhs <= lhs;
	endfunction

	function automatic class_t classify_voxel(voxel_t v);
		longint p [3];
		longint r [3];
		int n;
		class_t c;
		n = 0;
		for (int a = 0; a < 3; a++)
			p[a] = offset_of(v.center, a);
		if (v.ok && (p[0] != 0 || p[1] != 0 || p[2] != 0)) begin
			for (int k = 0; k < vsc_pkg::NUM_NBR; k++) begin
				if (!v.mask[k])
					continue;
				for (int a = 0; a < 3; a++)
					r[a] = offset_of(v.nbr[k], a);
				r[k/2] += (k % 2) ? 1 : -1;
				// a neighbor pointing back to itself is never a basis point
				if (r[0] == 0 && r[1] == 0 && r[2] == 0)
					continue;
				if (is_separated(r, p, cur_thr))
					n++;
			end
		end
		c.on = n > 0;
		c.cnt = n[vsc_pkg::CNT_BITS-1:0];
		if (cur_mode) begin
			c.face = c.on;
			c.edge_c = 1'b0;
			c.vert = 1'b0;
		end else begin
			c.face = n == 2;
			c.edge_c = n == 3;
			c.vert = n == 4;
		end
		return c;
	endfunction

	function automatic logic [vsc_pkg::PACK_BITS-1:0] pack_offset(int x, int y, int z);
		return {8'(z), 8'(y), 8'(x)};
	endfunction

	// send one word, with an optional idle gap ahead of it
	task automatic send_word(voxel_t v);
		int gap;
		gap = quiet ? 0 : $urandom_range(16);
		if ($urandom_range(3) == 0)
			gap = 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		center_parent <= v.center;
		center_ok <= v.ok;
		nbr_xm_parent <= v.nbr[0];
		nbr_xp_parent <= v.nbr[1];
		nbr_ym_parent <= v.nbr[2];
		nbr_yp_parent <= v.nbr[3];
		nbr_zm_parent <= v.nbr[4];
		nbr_zp_parent <= v.nbr[5];
		nbr_ok_mask <= v.mask;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		expected_classes.insert(expected_classes.size(), classify_voxel(v));
		words_sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (expected_classes.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// registers change only with the pipeline empty
	task automatic write_reg(logic [vsc_pkg::CFG_IDX_BITS-1:0] idx,
			logic [vsc_pkg::CFG_DATA_BITS-1:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == vsc_pkg::REG_COS_THRESHOLD)
			cur_thr = val;
		else
			cur_mode = val[0];
	endtask

	function automatic voxel_t random_voxel();
		voxel_t v;
		int sel;
		sel = $urandom_range(9);
		v.ok = $urandom_range(9) != 0;
		v.mask = vsc_pkg::NUM_NBR'($urandom);
		// mostly small offsets, like a real distance field; some full-range noise
		if (sel < 6)
			v.center = pack_offset($urandom_range(8) - 4, $urandom_range(8) - 4,
				$urandom_range(8) - 4)
				| vsc_pkg::PACK_BITS'($urandom_range(3) == 0 ? $urandom : 0);
		else
			v.center = vsc_pkg::PACK_BITS'($urandom);
		for (int k = 0; k < vsc_pkg::NUM_NBR; k++) begin
			if (sel < 6) begin
				case ($urandom_range(3))
					0: v.nbr[k] = v.center;
					// neighbor parent that cancels its own step
					1: v.nbr[k] = pack_offset((k == 0) ? 1 : (k == 1) ? -1 : 0,
						(k == 2) ? 1 : (k == 3) ? -1 : 0,
						(k == 4) ? 1 : (k == 5) ? -1 : 0);
					default: v.nbr[k] = pack_offset($urandom_range(8) - 4,
						$urandom_range(8) - 4, $urandom_range(8) - 4);
				endcase
			end else
				v.nbr[k] = vsc_pkg::PACK_BITS'($urandom);
		end
		if (sel == 9)
			v.center = '0;
		return v;
	endfunction

	// directed corners: usability, zero parents, cancelling neighbors, every class
	task automatic test_directed();
		voxel_t v;
		int masks [7] = '{6'h00, 6'h01, 6'h03, 6'h07, 6'h0f, 6'h1f, 6'h3f};
		quiet = 1'b1;
		v.center = pack_offset(10, 0, 0);
		v.ok = 1'b1;
		for (int k = 0; k < vsc_pkg::NUM_NBR; k++)
			v.nbr[k] = pack_offset(-20, 0, 0);
		foreach (masks[i]) begin
			v.mask = vsc_pkg::NUM_NBR'(masks[i]);
			send_word(v);
		end
		v.ok = 1'b0;
		send_word(v);
		v.ok = 1'b1;
		v.center = 24'h000000;
		send_word(v);
		v.center = 24'hff0000 | pack_offset(0, 0, 0);
		send_word(v);
		v.center = pack_offset(-128, 127, -128);
		for (int k = 0; k < vsc_pkg::NUM_NBR; k++)
			v.nbr[k] = pack_offset(127, -128, 127);
		send_word(v);
		v.nbr[0] = pack_offset(1, 0, 0);
		v.nbr[1] = pack_offset(-1, 0, 0);
		v.nbr[2] = pack_offset(0, 1, 0);
		v.nbr[3] = pack_offset(0, -1, 0);
		v.nbr[4] = pack_offset(0, 0, 1);
		v.nbr[5] = pack_offset(0, 0, -1);
		send_word(v);
		v.center = pack_offset(3, 0, 0);
		for (int k = 0; k < vsc_pkg::NUM_NBR; k++)
			v.nbr[k] = pack_offset(3, 0, 0);
		send_word(v);
		v.center = 24'hffffff;
		for (int k = 0; k < vsc_pkg::NUM_NBR; k++)
			v.nbr[k] = 24'h800000 | pack_offset(-128, -128, -128);
		send_word(v);
		drain();
	endtask

	task automatic random_block(int n);
		repeat (n)
			send_word(random_voxel());
	endtask

	// threshold extremes and neighbor mode, each with a random block
	task automatic test_settings();
		logic [15:0] thr [6] = '{16'h8000, 16'h7fff, 16'h0000, 16'hd99a, 16'h4000, 16'hffff};
		quiet = 1'b0;
		random_block(150);
		foreach (thr[i]) begin
			write_reg(vsc_pkg::REG_COS_THRESHOLD, thr[i]);
			write_reg(vsc_pkg::REG_NEIGHBOR_MODE, 16'(i % 2));
			random_block(120);
		end
		write_reg(vsc_pkg::REG_NEIGHBOR_MODE, 16'hfffe);
		write_reg(vsc_pkg::REG_COS_THRESHOLD, 16'(vsc_pkg::COS_RESET));
		quiet = 1'b1;
		random_block(60);
	endtask

	always @(posedge clk) begin
		class_t e;
		if (arst_n && done) begin
			results_seen++;
			if (expected_classes.size() == 0) begin
				$error("result with no word outstanding");
				errors++;
			end else begin
				e = expected_classes.pop_front();
				if (on_skel !== e.on) begin
					$error("on_skel exp %0d got %0d", e.on, on_skel); errors++;
				end
				if (basis_count !== e.cnt) begin
					$error("basis_count exp %0d got %0d", e.cnt, basis_count); errors++;
				end
				if (is_face !== e.face) begin
					$error("is_face exp %0d got %0d", e.face, is_face); errors++;
				end
				if (is_edge !== e.edge_c) begin
					$error("is_edge exp %0d got %0d", e.edge_c, is_edge); errors++;
				end
				if (is_vtx !== e.vert) begin
					$error("is_vtx exp %0d got %0d", e.vert, is_vtx); errors++;
				end
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 4000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_settings();
		drain();
		$display("covered %0d words, %0d results, thresholds at both extremes, both modes",
			words_sent, results_seen);
		if (errors == 0 && expected_classes.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
